FILE: src/itoa_fmt_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps

package itoa_fmt_pkg;

  // conversion codes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int RADIX_DEC  = 10;
  localparam int RADIX_HEX  = 16;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int WORD_BITS  = 32;
  localparam int DAB_STEPS  = 4;
  localparam int DAB_STAGES = WORD_BITS / DAB_STEPS;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  op;
    logic [5:0]  field_width;
    logic        align_left;
    logic        zero_fill;
  } arg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } txt_t;

  // one item in flight through the conversion stages
  typedef struct packed {
    logic [31:0]           bits;
    logic [4*DEC_DIGITS-1:0] bcd;
    logic                  neg;
    logic                  hex;
    logic [5:0]            field_width;
    logic                  align_left;
    logic                  zero_fill;
  } stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SIGN,
    ST_ZERO,
    ST_DIGIT,
    ST_POST
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'(RADIX_DEC)) begin
      c = CH_ZERO + {4'b0000, d};
    end else begin
      c = CH_A + {4'b0000, d} - 8'(RADIX_DEC);
    end
    return c;
  endfunction

endpackage

FILE: src/itoa_fmt_front.sv
// Input stage: sign handling and magnitude for the digit pipeline.
`timescale 1ns / 1ps

module itoa_fmt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itoa_fmt_pkg::arg_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output itoa_fmt_pkg::stage_t  out_data
);

  itoa_fmt_pkg::stage_t data_next;
  logic                 neg;

  assign in_stall = out_valid && out_stall;

  always_comb begin
    neg                   = (in_data.op == itoa_fmt_pkg::OP_SDEC) && in_data.value[31];
    data_next.neg         = neg;
    data_next.bits        = neg ? (32'd0 - in_data.value) : in_data.value;
    data_next.bcd         = '0;
    data_next.hex         = (in_data.op != itoa_fmt_pkg::OP_SDEC) &&
                            (in_data.op != itoa_fmt_pkg::OP_UDEC);
    data_next.field_width = in_data.field_width;
    data_next.align_left  = in_data.align_left;
    data_next.zero_fill   = in_data.zero_fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: src/itoa_fmt_dabble.sv
// One shift-and-add-3 stage of the binary to BCD conversion.
`timescale 1ns / 1ps

module itoa_fmt_dabble (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itoa_fmt_pkg::stage_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output itoa_fmt_pkg::stage_t  out_data
);

  itoa_fmt_pkg::stage_t data_next;

  assign in_stall = out_valid && out_stall;

  // hex items pass untouched; their nibbles are read directly later
  always_comb begin
    data_next = in_data;
    if (!in_data.hex) begin
      for (int s = 0; s < itoa_fmt_pkg::DAB_STEPS; s++) begin
        for (int d = 0; d < itoa_fmt_pkg::DEC_DIGITS; d++) begin
          if (data_next.bcd[4*d +: 4] >= 4'd5) begin
            data_next.bcd[4*d +: 4] = data_next.bcd[4*d +: 4] + 4'd3;
          end
        end
        {data_next.bcd, data_next.bits} = {data_next.bcd, data_next.bits} << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: src/itoa_fmt_emit.sv
// Character sequencer: padding, sign and digits, one character per beat.
`timescale 1ns / 1ps

module itoa_fmt_emit #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itoa_fmt_pkg::stage_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output itoa_fmt_pkg::txt_t    out_data
);

  localparam logic [5:0] WCAP = 6'((MAX_WIDTH > 63) ? 63 : MAX_WIDTH);

  itoa_fmt_pkg::state_t state, state_next;

  logic [4*itoa_fmt_pkg::DEC_DIGITS-1:0] digits;
  logic       neg;
  logic       zmode;
  logic       lpad;
  logic [5:0] pad_cnt;
  logic [3:0] dig_idx;

  logic [4*itoa_fmt_pkg::DEC_DIGITS-1:0] digs_in;
  logic [3:0] nd_in;
  logic [3:0] body_in;
  logic [5:0] width_c;
  logic [5:0] pad_in;
  logic       zmode_in;

  logic       load;
  logic       adv;
  logic [7:0] emit_char;
  logic       emit_last;

  assign in_stall = (state != itoa_fmt_pkg::ST_IDLE);
  assign load     = (state == itoa_fmt_pkg::ST_IDLE) && in_valid;
  assign adv      = (state != itoa_fmt_pkg::ST_IDLE) && (!out_valid || !out_stall);

  // digit count and pad length of the incoming item
  always_comb begin
    digs_in = in_data.hex ? {8'h00, in_data.bits} : in_data.bcd;
    nd_in   = 4'd1;
    for (int i = 1; i < itoa_fmt_pkg::DEC_DIGITS; i++) begin
      if (digs_in[4*i +: 4] != 4'd0) begin
        nd_in = 4'(i + 1);
      end
    end
    body_in  = nd_in + {3'b000, in_data.neg};
    width_c  = (in_data.field_width > WCAP) ? WCAP : in_data.field_width;
    pad_in   = (width_c > {2'b00, body_in}) ? (width_c - {2'b00, body_in}) : 6'd0;
    zmode_in = in_data.zero_fill && (width_c != 6'd0);
  end

  always_comb begin
    state_next = state;
    case (state)
      itoa_fmt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (zmode_in) begin
            if (in_data.neg) begin
              state_next = itoa_fmt_pkg::ST_SIGN;
            end else if (pad_in != 6'd0) begin
              state_next = itoa_fmt_pkg::ST_ZERO;
            end else begin
              state_next = itoa_fmt_pkg::ST_DIGIT;
            end
          end else if (!in_data.align_left && pad_in != 6'd0) begin
            state_next = itoa_fmt_pkg::ST_PRE;
          end else if (in_data.neg) begin
            state_next = itoa_fmt_pkg::ST_SIGN;
          end else begin
            state_next = itoa_fmt_pkg::ST_DIGIT;
          end
        end
      end
      itoa_fmt_pkg::ST_PRE: begin
        if (adv && pad_cnt == 6'd1) begin
          state_next = neg ? itoa_fmt_pkg::ST_SIGN : itoa_fmt_pkg::ST_DIGIT;
        end
      end
      itoa_fmt_pkg::ST_SIGN: begin
        if (adv) begin
          state_next = (zmode && pad_cnt != 6'd0) ? itoa_fmt_pkg::ST_ZERO
                                                  : itoa_fmt_pkg::ST_DIGIT;
        end
      end
      itoa_fmt_pkg::ST_ZERO: begin
        if (adv && pad_cnt == 6'd1) begin
          state_next = itoa_fmt_pkg::ST_DIGIT;
        end
      end
      itoa_fmt_pkg::ST_DIGIT: begin
        if (adv && dig_idx == 4'd0) begin
          state_next = (lpad && pad_cnt != 6'd0) ? itoa_fmt_pkg::ST_POST
                                                 : itoa_fmt_pkg::ST_IDLE;
        end
      end
      itoa_fmt_pkg::ST_POST: begin
        if (adv && pad_cnt == 6'd1) begin
          state_next = itoa_fmt_pkg::ST_IDLE;
        end
      end
      default: state_next = itoa_fmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit_char = itoa_fmt_pkg::CH_SPACE;
    emit_last = 1'b0;
    case (state)
      itoa_fmt_pkg::ST_PRE: begin
        emit_char = itoa_fmt_pkg::CH_SPACE;
      end
      itoa_fmt_pkg::ST_SIGN: begin
        emit_char = itoa_fmt_pkg::CH_MINUS;
      end
      itoa_fmt_pkg::ST_ZERO: begin
        emit_char = itoa_fmt_pkg::CH_ZERO;
      end
      itoa_fmt_pkg::ST_DIGIT: begin
        emit_char = itoa_fmt_pkg::digit_char(digits[{dig_idx, 2'b00} +: 4]);
        emit_last = (dig_idx == 4'd0) && !(lpad && pad_cnt != 6'd0);
      end
      itoa_fmt_pkg::ST_POST: begin
        emit_char = itoa_fmt_pkg::CH_SPACE;
        emit_last = (pad_cnt == 6'd1);
      end
      default: begin
        emit_char = itoa_fmt_pkg::CH_SPACE;
        emit_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_fmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits  <= digs_in;
      neg     <= in_data.neg;
      zmode   <= zmode_in;
      lpad    <= in_data.align_left && !zmode_in;
      pad_cnt <= pad_in;
      dig_idx <= nd_in - 4'd1;
    end else if (adv) begin
      if (state == itoa_fmt_pkg::ST_PRE || state == itoa_fmt_pkg::ST_ZERO ||
          state == itoa_fmt_pkg::ST_POST) begin
        pad_cnt <= pad_cnt - 6'd1;
      end
      if (state == itoa_fmt_pkg::ST_DIGIT && dig_idx != 4'd0) begin
        dig_idx <= dig_idx - 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= (state != itoa_fmt_pkg::ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data.char_code <= emit_char;
      out_data.is_last   <= emit_last;
    end
  end

`ifndef SYNTHESIS
  ast_digit_range: assert property (@(posedge clk) disable iff (rst)
    state == itoa_fmt_pkg::ST_DIGIT |-> dig_idx < 4'(itoa_fmt_pkg::DEC_DIGITS))
    else $error("digit index out of range");

  ast_pad_live: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_fmt_pkg::ST_PRE || state == itoa_fmt_pkg::ST_ZERO ||
     state == itoa_fmt_pkg::ST_POST) |-> pad_cnt != 6'd0)
    else $error("padding state with empty pad count");

  ast_last_ends: assert property (@(posedge clk) disable iff (rst)
    (adv && emit_last) |=> state == itoa_fmt_pkg::ST_IDLE)
    else $error("sequencer kept running after the last character");

  ast_idle_no_last: assert property (@(posedge clk) disable iff (rst)
    (adv && !emit_last) |=> state != itoa_fmt_pkg::ST_IDLE)
    else $error("sequencer went idle without a last character");
`endif

endmodule

FILE: src/integer_to_ascii_formatter.sv
// Order: input register, eight BCD stages, character sequencer, output register.
// Throughput: one character per cycle while txt_stall is low; a new item
//   enters the sequencer only after the last one has sent every character.
// The input register and eight BCD stages can hold nine items while it works.
// Reset clears all valid bits and returns the sequencer to idle.
`timescale 1ns / 1ps

module integer_to_ascii_formatter #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                arg_valid,
  output logic                arg_stall,
  input  itoa_fmt_pkg::arg_t  arg,
  output logic                txt_valid,
  input  logic                txt_stall,
  output itoa_fmt_pkg::txt_t  txt
);

  localparam int NS = itoa_fmt_pkg::DAB_STAGES;

  logic                 stg_valid [NS+1];
  logic                 stg_stall [NS+1];
  itoa_fmt_pkg::stage_t stg_data  [NS+1];

  itoa_fmt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (arg_valid),
    .in_stall  (arg_stall),
    .in_data   (arg),
    .out_valid (stg_valid[0]),
    .out_stall (stg_stall[0]),
    .out_data  (stg_data[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_dab
    itoa_fmt_dabble u_dab (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_stall  (stg_stall[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_stall (stg_stall[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  itoa_fmt_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[NS]),
    .in_stall  (stg_stall[NS]),
    .in_data   (stg_data[NS]),
    .out_valid (txt_valid),
    .out_stall (txt_stall),
    .out_data  (txt)
  );

endmodule

FILE: dv/integer_to_ascii_formatter_test.sv
// Self-checking testbench for the integer to ASCII formatter.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;

  localparam int          FIELD_MAX      = 32;
  localparam logic [1:0]  OP_SPARE       = 2'd3;   // unused code, formats as hex
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 60;
  localparam int          PHASE_ITEMS    = 120;

  // expected characters of every accepted conversion, in output order
  class itoa_scoreboard;
    itoa_fmt_pkg::txt_t expected_chars[$];
    int   fails;

    function new();
      fails = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_arg(itoa_fmt_pkg::arg_t a);
      logic [31:0]  mag;
      logic [3:0]   d;
      logic         neg;
      int unsigned  radix;
      int unsigned  wid;
      int unsigned  body;
      int unsigned  pad;
      logic [7:0]   digs[$];
      logic [7:0]   line[$];
      itoa_fmt_pkg::txt_t c;
      radix = (a.op == itoa_fmt_pkg::OP_SDEC || a.op == itoa_fmt_pkg::OP_UDEC)
              ? itoa_fmt_pkg::RADIX_DEC : itoa_fmt_pkg::RADIX_HEX;
      neg = (a.op == itoa_fmt_pkg::OP_SDEC) && a.value[31];
      mag = neg ? (~a.value + 32'd1) : a.value;
      do begin
        d = 4'(mag % radix);
        if (d < 4'(itoa_fmt_pkg::RADIX_DEC)) begin
          digs.push_front(itoa_fmt_pkg::CH_ZERO + 8'(d));
        end else begin
          digs.push_front(itoa_fmt_pkg::CH_A + 8'(d) - 8'(itoa_fmt_pkg::RADIX_DEC));
        end
        mag = mag / radix;
      end while (mag != 0);
      wid = (a.field_width > FIELD_MAX) ? FIELD_MAX : a.field_width;
      body = digs.size() + (neg ? 1 : 0);
      pad = (wid > body) ? wid - body : 0;
      // zero fill wins over left alignment, and the sign goes ahead of the zeros
      if (a.zero_fill && wid != 0) begin
        if (neg) line.push_back(itoa_fmt_pkg::CH_MINUS);
        repeat (pad) line.push_back(itoa_fmt_pkg::CH_ZERO);
        line = {line, digs};
      end else begin
        if (!a.align_left) repeat (pad) line.push_back(itoa_fmt_pkg::CH_SPACE);
        if (neg) line.push_back(itoa_fmt_pkg::CH_MINUS);
        line = {line, digs};
        if (a.align_left) repeat (pad) line.push_back(itoa_fmt_pkg::CH_SPACE);
      end
      foreach (line[i]) begin
        c.char_code = line[i];
        c.is_last = (i == line.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_txt(itoa_fmt_pkg::txt_t t);
      itoa_fmt_pkg::txt_t e;
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: char_code %h is_last %b", t.char_code, t.is_last);
        fails++;
      end else begin
        e = expected_chars.pop_front();
        if (t.char_code !== e.char_code) begin
          $error("char_code: expected %h, actual %h", e.char_code, t.char_code);
          fails++;
        end
        if (t.is_last !== e.is_last) begin
          $error("is_last: expected %b, actual %b", e.is_last, t.is_last);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic arg_valid = 1'b0;
  logic arg_stall;
  itoa_fmt_pkg::arg_t arg = '0;
  logic txt_valid;
  logic txt_stall = 1'b0;
  itoa_fmt_pkg::txt_t txt;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        long_hold_go = 1'b0;
  int          quiet_cycles = 0;

  itoa_scoreboard sb = new();

  integer_to_ascii_formatter #(
    .MAX_WIDTH(FIELD_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .arg_valid(arg_valid),
    .arg_stall(arg_stall),
    .arg      (arg),
    .txt_valid(txt_valid),
    .txt_stall(txt_stall),
    .txt      (txt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic itoa_fmt_pkg::arg_t make_arg(logic [31:0] value, logic [1:0] op,
                                                  logic [5:0] w, logic left, logic zf);
    itoa_fmt_pkg::arg_t a;
    a.value = value;
    a.op = op;
    a.field_width = w;
    a.align_left = left;
    a.zero_fill = zf;
    return a;
  endfunction

  function automatic itoa_fmt_pkg::arg_t random_arg();
    itoa_fmt_pkg::arg_t a;
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0: a.value = $urandom_range(20);
      1: a.value = -$urandom_range(20);
      2: a.value = $urandom_range(65535);
      3: begin
        case ($urandom_range(4))
          0: a.value = 32'h8000_0000;
          1: a.value = 32'h7FFF_FFFF;
          2: a.value = 32'hFFFF_FFFF;
          3: a.value = 32'h0000_0000;
          default: a.value = 32'h0000_0001;
        endcase
      end
      default: a.value = $urandom;
    endcase
    a.op = 2'($urandom_range(3));
    // mostly short fields, now and then wider ones, some past the clamp
    if ($urandom_range(7) == 0) begin
      a.field_width = 6'($urandom_range(17, 63));
    end else begin
      a.field_width = 6'($urandom_range(16));
    end
    a.align_left = 1'($urandom_range(1));
    a.zero_fill = 1'($urandom_range(1));
    return a;
  endfunction

  // valid stays up across back-to-back beats; it only drops in a gap
  task automatic send_arg(input itoa_fmt_pkg::arg_t a);
    while ($urandom_range(99) < tx_idle_pct) begin
      arg_valid <= 1'b0;
      @(posedge clk);
    end
    arg <= a;
    arg_valid <= 1'b1;
    @(posedge clk);
    while (arg_stall) @(posedge clk);
    sb.note_arg(a);
  endtask

  initial begin : rx_side
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_hold_go && !held) begin
        // long hold-off so the block backs up and stalls its input
        held = 1;
        txt_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      txt_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (txt_valid && !txt_stall) sb.check_txt(txt);
      if ((arg_valid && !arg_stall) || (txt_valid && !txt_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stim
    itoa_fmt_pkg::arg_t directed[$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_arg(32'd0,          itoa_fmt_pkg::OP_SDEC, 6'd0,  1'b0, 1'b0));
    directed.push_back(make_arg(32'd0,          itoa_fmt_pkg::OP_UDEC, 6'd5,  1'b0, 1'b0));
    directed.push_back(make_arg(32'd0,          itoa_fmt_pkg::OP_HEX,  6'd3,  1'b0, 1'b1));
    directed.push_back(make_arg(32'h8000_0000,  itoa_fmt_pkg::OP_SDEC, 6'd0,  1'b0, 1'b0));
    directed.push_back(make_arg(32'h8000_0000,  itoa_fmt_pkg::OP_SDEC, 6'd14, 1'b0, 1'b1));
    directed.push_back(make_arg(32'h8000_0000,  itoa_fmt_pkg::OP_UDEC, 6'd0,  1'b1, 1'b0));
    directed.push_back(make_arg(32'hFFFF_FFFF,  itoa_fmt_pkg::OP_SDEC, 6'd4,  1'b0, 1'b1));
    directed.push_back(make_arg(32'hFFFF_FFFF,  itoa_fmt_pkg::OP_UDEC, 6'd12, 1'b1, 1'b0));
    directed.push_back(make_arg(32'hFFFF_FFFF,  itoa_fmt_pkg::OP_HEX,  6'd0,  1'b0, 1'b0));
    directed.push_back(make_arg(32'hFFFF_FFFF,  OP_SPARE,              6'd10, 1'b0, 1'b0));
    directed.push_back(make_arg(32'h7FFF_FFFF,  itoa_fmt_pkg::OP_SDEC, 6'd11, 1'b0, 1'b0));
    directed.push_back(make_arg(32'hABCD_EF01,  OP_SPARE,              6'd63, 1'b1, 1'b0));
    directed.push_back(make_arg(32'h0001_2345,  itoa_fmt_pkg::OP_HEX,  6'd32, 1'b1, 1'b1));
    directed.push_back(make_arg(32'd42,         itoa_fmt_pkg::OP_UDEC, 6'd0,  1'b0, 1'b1));
    directed.push_back(make_arg(-32'sd42,       itoa_fmt_pkg::OP_SDEC, 6'd1,  1'b0, 1'b0));
    directed.push_back(make_arg(32'd1234567890, itoa_fmt_pkg::OP_UDEC, 6'd10, 1'b1, 1'b0));
    directed.push_back(make_arg(32'd5,          itoa_fmt_pkg::OP_SDEC, 6'd63, 1'b0, 1'b1));
    directed.push_back(make_arg(-32'sd7,        itoa_fmt_pkg::OP_SDEC, 6'd40, 1'b1, 1'b0));
    directed.push_back(make_arg(32'h0000_FFFF,  itoa_fmt_pkg::OP_HEX,  6'd6,  1'b0, 1'b0));
    directed.push_back(make_arg(32'hDEAD_BEEF,  itoa_fmt_pkg::OP_SDEC, 6'd33, 1'b1, 1'b1));
    foreach (directed[i]) send_arg(directed[i]);

    tx_idle_pct = 35;
    rx_idle_pct = 72;
    repeat (PHASE_ITEMS) send_arg(random_arg());

    tx_idle_pct = 72;
    rx_idle_pct = 35;
    repeat (PHASE_ITEMS) send_arg(random_arg());

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_go <= 1'b1;
    repeat (PHASE_ITEMS) send_arg(random_arg());
    arg_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
